// File: sv/ble_pkg.sv
// Package for the bounded list engine: command and status codes, FSM states,
// request/result beat types and the per-cell control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ble_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 16;
  localparam int COUNT_W      = 7;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_DELETE_AT  = 3'd5,
    CMD_SEARCH     = 3'd6,
    CMD_READ_AT    = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_RANGE   = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE
  } state_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_beat_t;

  typedef struct packed {
    status_t                 status;
    logic                    found;
    logic signed [VAL_W-1:0] data;
    logic [COUNT_W-1:0]      count;
  } out_beat_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic srch;
    logic pick;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: sv/ble_cell.sv
// One storage cell of the list chain: holds one entry, shifts toward either
// neighbor on insert/delete, flags search matches and captures a picked entry.
// Depends on ble_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ble_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  wire logic                             clk,
  input  wire ble_pkg::cell_ctl_t               ctl,
  input  wire logic [IDX_W-1:0]                 idx,
  input  wire logic [CNT_W-1:0]                 cnt,
  input  wire logic signed [ble_pkg::VAL_W-1:0] value,
  input  wire logic signed [ble_pkg::VAL_W-1:0] left,
  input  wire logic signed [ble_pkg::VAL_W-1:0] right,
  output logic signed [ble_pkg::VAL_W-1:0]      q,
  output logic                                  hit,
  output logic signed [ble_pkg::VAL_W-1:0]      pick_data
);
  import ble_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                    at_idx;
  logic                    above_idx;
  logic                    occupied;
  logic signed [VAL_W-1:0] q_next;

  assign at_idx    = (idx == MY_IDX);
  assign above_idx = (MY_IDX > idx);
  assign occupied  = (CNT_W'(IDX) < cnt);

  always_comb begin
    q_next = q;
    if (ctl.ins) begin
      if (above_idx) begin
        q_next = left;
      end else if (at_idx) begin
        q_next = value;
      end
    end else if (ctl.del) begin
      if (above_idx || at_idx) begin
        q_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    q         <= q_next;
    hit       <= ctl.srch && occupied && (q == value);
    pick_data <= (ctl.pick && at_idx) ? q : '0;
  end

endmodule
`default_nettype wire

// File: sv/bounded_list_engine_top.sv
// Bounded list engine: ordered list held in a chain of cells with positional
// insert/delete, search and read. Each accepted command passes through S_EXEC
// (cell update) and S_REDUCE (a gather of the cell hit flags and picked data
// through an OR tree); the registered result strobe "done" follows S_REDUCE.
// No new command is taken while busy. The receiver cannot stall.
// Synchronous reset empties the list; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bounded_list_engine_top #(
  parameter int CAPACITY = ble_pkg::DEF_CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire ble_pkg::in_beat_t request,
  output logic                   done,
  output ble_pkg::out_beat_t     result
);
  import ble_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = POS_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  state_t                  state;
  state_t                  state_next;
  in_beat_t                req_q;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;
  status_t                 st_q;
  status_t                 st_next;
  logic                    srch_q;
  cell_ctl_t               ctl;
  logic [IDX_W-1:0]        idx;
  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  logic [CMP_W-1:0]        pos_ext;
  logic [CMP_W-1:0]        cnt_ext;
  logic                    any_hit;
  logic signed [VAL_W-1:0] gather;

  logic signed [VAL_W-1:0] cell_q    [CAPACITY];
  logic signed [VAL_W-1:0] cell_pick [CAPACITY];
  logic [CAPACITY-1:0]     cell_hit;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (cnt == CNT_FULL);
  assign is_empty = (cnt == '0);
  assign pos_ext  = CMP_W'(req_q.position);
  assign cnt_ext  = CMP_W'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    idx        = '0;
    st_next    = ST_OK;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_REDUCE;
        case (req_q.cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (is_full) begin
              st_next = ST_FULL;
            end else begin
              ctl.ins  = 1'b1;
              idx      = (req_q.cmd == CMD_PUSH_FRONT) ? '0 : IDX_W'(cnt);
              cnt_next = cnt + 1'b1;
            end
          end
          CMD_INSERT_AT: begin
            if (req_q.position == '0) begin
              st_next = ST_INVALID;
            end else if (pos_ext > cnt_ext + 1'b1) begin
              st_next = ST_RANGE;
            end else if (is_full) begin
              st_next = ST_FULL;
            end else begin
              ctl.ins  = 1'b1;
              idx      = IDX_W'(req_q.position - 1'b1);
              cnt_next = cnt + 1'b1;
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (is_empty) begin
              st_next = ST_EMPTY;
            end else begin
              ctl.del  = 1'b1;
              ctl.pick = 1'b1;
              idx      = (req_q.cmd == CMD_POP_FRONT) ? '0 : IDX_W'(cnt - 1'b1);
              cnt_next = cnt - 1'b1;
            end
          end
          CMD_DELETE_AT, CMD_READ_AT: begin
            if (req_q.position == '0) begin
              st_next = ST_INVALID;
            end else if (is_empty) begin
              st_next = ST_EMPTY;
            end else if (pos_ext > cnt_ext) begin
              st_next = ST_RANGE;
            end else begin
              ctl.pick = 1'b1;
              idx      = IDX_W'(req_q.position - 1'b1);
              if (req_q.cmd == CMD_DELETE_AT) begin
                ctl.del  = 1'b1;
                cnt_next = cnt - 1'b1;
              end
            end
          end
          CMD_SEARCH: begin
            ctl.srch = 1'b1;
          end
          default: begin
            st_next = ST_OK;
          end
        endcase
      end
      S_REDUCE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [VAL_W-1:0] left;
      logic signed [VAL_W-1:0] right;
      if (gi == 0) begin : g_first
        assign left = '0;
      end else begin : g_mid_l
        assign left = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right = '0;
      end else begin : g_mid_r
        assign right = cell_q[gi+1];
      end
      ble_cell #(
        .IDX   (gi),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .idx       (idx),
        .cnt       (cnt),
        .value     (req_q.value),
        .left      (left),
        .right     (right),
        .q         (cell_q[gi]),
        .hit       (cell_hit[gi]),
        .pick_data (cell_pick[gi])
      );
    end
  endgenerate

  always_comb begin
    gather = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      gather = gather | cell_pick[i];
    end
  end

  assign any_hit = |cell_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= (state == S_REDUCE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
    if (state == S_EXEC) begin
      st_q   <= st_next;
      srch_q <= (req_q.cmd == CMD_SEARCH);
    end
    if (state == S_REDUCE) begin
      result.status <= st_q;
      result.found  <= srch_q && any_hit;
      result.data   <= (st_q == ST_OK) ? gather : '0;
      result.count  <= COUNT_W'(cnt);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("entry count above capacity");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("no result three cycles after accept");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_REDUCE))
    else $error("result strobe without gather cycle");

  a_data_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.data == '0 && !result.found))
    else $error("data or found set on failed command");

endmodule
`default_nettype wire
